[src/assert_macros.svh]
// Assertion macros for the SLIP deframer RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion: prop is a full property expression.
`define SFDC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sfdc assertion failed");

// Next-cycle implication.
`define SFDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfdc next-cycle assertion failed");

`endif

[src/sfdc_pkg.sv]
// Shared types, codes and functions for the SLIP deframer with CRC-16 check.
// No dependencies; imported by the interfaces and every module.
package sfdc_pkg;

	localparam int unsigned BYTE_W              = 8;
	localparam int unsigned LEN_W               = 13;
	localparam int unsigned CRC_W               = 16;
	localparam int unsigned CFG_IDX_W           = 3;
	localparam int unsigned CFG_DATA_W          = 16;
	localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;

	localparam logic [BYTE_W-1:0] END_CODE      = 8'hC0;
	localparam logic [BYTE_W-1:0] ESC_CODE      = 8'hDB;
	localparam logic [BYTE_W-1:0] ESC_END_CODE  = 8'hDC;
	localparam logic [BYTE_W-1:0] ESC_ESC_CODE  = 8'hDD;
	localparam logic [BYTE_W-1:0] ESC_XON_CODE  = 8'hDE;
	localparam logic [BYTE_W-1:0] ESC_XOFF_CODE = 8'hDF;
	localparam logic [BYTE_W-1:0] XON_CODE      = 8'h11;
	localparam logic [BYTE_W-1:0] XOFF_CODE     = 8'h13;

	localparam logic [CRC_W-1:0] POLY_RST = 16'h1021;
	localparam logic [CRC_W-1:0] INIT_RST = 16'hFFFF;
	localparam logic [CRC_W-1:0] FXOR_RST = 16'h0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY = 3'd0,
		REG_INIT = 3'd1,
		REG_FXOR = 3'd2,
		REG_REFL = 3'd3,
		REG_HBF  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CRC_W-1:0] poly;
		logic [CRC_W-1:0] init;
		logic [CRC_W-1:0] fxor;
		logic             refl;
		logic             hbf;
	} crc_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_end;
		logic              frame_good;
		logic              frame_short;
		logic [LEN_W-1:0]  payload_length;
	} frame_res_t;

	function automatic logic [BYTE_W-1:0] unescape(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] d;
		unique case (b)
			ESC_END_CODE:  d = END_CODE;
			ESC_ESC_CODE:  d = ESC_CODE;
			ESC_XON_CODE:  d = XON_CODE;
			ESC_XOFF_CODE: d = XOFF_CODE;
			default:       d = b;
		endcase
		return d;
	endfunction

	function automatic logic [CRC_W-1:0] crc16_byte(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] b,
		input logic [CRC_W-1:0]  poly,
		input logic              refl
	);
		logic [CRC_W-1:0] c;
		logic [CRC_W-1:0] rpoly;
		for (int i = 0; i < CRC_W; i++) begin
			rpoly[i] = poly[CRC_W-1-i];
		end
		if (refl) begin
			c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
			for (int i = 0; i < BYTE_W; i++) begin
				c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
			end
		end else begin
			c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
			for (int i = 0; i < BYTE_W; i++) begin
				c = c[CRC_W-1] ? ((c << 1) ^ poly) : (c << 1);
			end
		end
		return c;
	endfunction

endpackage

[src/sfdc_ifs.sv]
// Valid/ready channel interfaces: received line bytes and deframer results.
// Depends on sfdc_pkg for field widths.
interface sfdc_byte_if import sfdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfdc_result_if import sfdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	logic              frame_end;
	logic              frame_good;
	logic              frame_short;
	logic [LEN_W-1:0]  payload_length;

	modport source (output valid, output payload_byte, output frame_end,
		output frame_good, output frame_short, output payload_length, input ready);
	modport sink (input valid, input payload_byte, input frame_end,
		input frame_good, input frame_short, input payload_length, output ready);
endinterface

[src/sfdc_cfg_regs.sv]
// CRC configuration register bank behind a plain write port.
// Depends on sfdc_pkg.
module sfdc_cfg_regs import sfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output crc_cfg_t              cfg
);

	crc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly <= POLY_RST;
			cfg_q.init <= INIT_RST;
			cfg_q.fxor <= FXOR_RST;
			cfg_q.refl <= 1'b0;
			cfg_q.hbf  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POLY: cfg_q.poly <= cfg_wdata[CRC_W-1:0];
				REG_INIT: cfg_q.init <= cfg_wdata[CRC_W-1:0];
				REG_FXOR: cfg_q.fxor <= cfg_wdata[CRC_W-1:0];
				REG_REFL: cfg_q.refl <= cfg_wdata[0];
				REG_HBF:  cfg_q.hbf  <= cfg_wdata[0];
				default:  ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/sfdc_deframer.sv]
// Frame state and per-byte logic: unescape, CRC holdback, CRC update, frame-end verdict.
// Depends on sfdc_pkg.
module sfdc_deframer import sfdc_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crc_cfg_t          cfg,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              res_valid,
	output frame_res_t        res
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic              esc_q;
	logic [1:0]        held_count_q;
	logic [BYTE_W-1:0] held0_q;
	logic [BYTE_W-1:0] held1_q;
	logic [CRC_W-1:0]  crc_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              is_data;
	logic              is_end;
	logic              is_esc;
	logic [BYTE_W-1:0] data;
	logic              emit;
	logic [CRC_W-1:0]  crc_base;
	logic [CRC_W-1:0]  crc_calc;
	logic [CRC_W-1:0]  crc_rx;
	logic              shrt;
	logic [LEN_W-1:0]  len;

	always_comb begin
		is_data = 1'b0;
		is_end  = 1'b0;
		is_esc  = 1'b0;
		data    = rx_byte;
		priority if (esc_q) begin
			is_data = 1'b1;
			data    = unescape(rx_byte);
		end else if (rx_byte == END_CODE) begin
			is_end = 1'b1;
		end else if (rx_byte == ESC_CODE) begin
			is_esc = 1'b1;
		end else begin
			is_data = 1'b1;
		end
	end

	generate
		if (CNT_W >= LEN_W) begin : g_len_trunc
			assign len = cnt_q[LEN_W-1:0];
		end else begin : g_len_ext
			assign len = {{(LEN_W-CNT_W){1'b0}}, cnt_q};
		end
	endgenerate

	assign emit     = is_data && (held_count_q == 2'd2);
	assign crc_base = (cnt_q == '0) ? cfg.init : crc_q;
	assign crc_calc = crc_base ^ cfg.fxor;
	assign crc_rx   = cfg.hbf ? {held0_q, held1_q} : {held1_q, held0_q};
	assign shrt     = (held_count_q != 2'd2);

	always_comb begin
		res = '0;
		if (is_end) begin
			res.frame_end      = 1'b1;
			res.frame_short    = shrt;
			res.frame_good     = !shrt && (crc_calc == crc_rx);
			res.payload_length = len;
		end else begin
			res.payload_byte = held0_q;
		end
	end

	assign res_valid = is_end || emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q        <= 1'b0;
			held_count_q <= 2'd0;
			cnt_q        <= '0;
		end else if (step) begin
			esc_q <= is_esc;
			if (is_end) begin
				held_count_q <= 2'd0;
				cnt_q        <= '0;
			end else if (is_data) begin
				if (!emit) begin
					held_count_q <= held_count_q + 2'd1;
				end else if (cnt_q < CNT_W'(MAX_FRAME_BYTES)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_data) begin
			if (emit) begin
				crc_q   <= crc16_byte(crc_base, held0_q, cfg.poly, cfg.refl);
				held0_q <= held1_q;
				held1_q <= data;
			end else if (held_count_q == 2'd0) begin
				held0_q <= data;
			end else begin
				held1_q <= data;
			end
		end
	end

endmodule

[src/slip_frame_decoder_crc16_unit.sv]
// SLIP deframer with CRC-16 check: input register, deframer logic, result register.
// Path: a transferred byte is held in the input register; any result it causes is registered in the result register.
// Throughput: one byte per cycle while the result channel is not stalled; the byte-wide CRC update sets the clock path.
// Reset: CRC configuration registers return to defaults and the frame state clears; no clearing pass.
// Depends on sfdc_pkg, sfdc_ifs, sfdc_cfg_regs, sfdc_deframer, assert_macros.svh.
`include "assert_macros.svh"

module slip_frame_decoder_crc16_unit import sfdc_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sfdc_byte_if.sink             rx,
	sfdc_result_if.source         res
);

	crc_cfg_t          cfg;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv_s1;
	logic              core_valid;
	frame_res_t        core_res;
	logic              out_valid_q;
	frame_res_t        result_q;

	sfdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sfdc_deframer #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (adv_s1),
		.rx_byte   (byte_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	assign adv_s1   = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && core_valid) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && core_valid) begin
			result_q <= core_res;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.payload_byte   = result_q.payload_byte;
	assign res.frame_end      = result_q.frame_end;
	assign res.frame_good     = result_q.frame_good;
	assign res.frame_short    = result_q.frame_short;
	assign res.payload_length = result_q.payload_length;

	`SFDC_ASSERT_NEXT(a_result_loaded, adv_s1 && core_valid, out_valid_q)
	`SFDC_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s1, valid_s1 && $stable(byte_s1))
	`SFDC_ASSERT(a_end_fields, out_valid_q && result_q.frame_end |-> result_q.payload_byte == '0)
	`SFDC_ASSERT(a_end_verdict, out_valid_q && result_q.frame_short |-> !result_q.frame_good)
	`SFDC_ASSERT(a_no_overwrite, out_valid_q && !res.ready |-> !adv_s1)

endmodule
